/* rtl/pss_pkg.sv */
package pss_pkg;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DEPTH,
    S_CHECK
  } pss_state_e;

  typedef enum logic {
    MODE_CALL   = 1'b0,
    MODE_RETURN = 1'b1
  } pss_mode_e;

  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_RET_OK    = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_FRAME_BAD = 3'd3;
  localparam logic [2:0] ST_RET_BAD   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [63:0] frame;
    logic [63:0] ret;
    logic [31:0] index;
  } pss_entry_t;

endpackage

/* rtl/pss_depth_mem.sv */
module pss_depth_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int WIDTH  = 5
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pss_entry_mem.sv */
module pss_entry_mem #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   addr_i,
  input  pss_pkg::pss_entry_t wdata_i,
  output pss_pkg::pss_entry_t rdata_o
);

  import pss_pkg::*;

  pss_entry_t mem_q [DEPTH];
  pss_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/per_routine_shadow_stack.sv */
// Channel   | Direction | Handshake             | Payload
// command   | in        | start high, busy low  | mode_i, routine_id_i, frame_pointer_i,
//           |           |                       | code_address_i
// result    | out       | done_o, one cycle     | status_o, call_index_o, stack_depth_o
//
// A call, or a return on an empty stack, keeps busy high through state S_DEPTH after its transfer;
// any other return keeps busy high through S_DEPTH and then S_CHECK.
// These states are set by the registered reads of the depth memory and the entry memory.
// The result strobe comes in the cycle after the last busy cycle.
// After reset busy stays high in state S_CLEAR while every depth memory entry is cleared.
// The receiver cannot stall; every result is taken in its strobe cycle.
module per_routine_shadow_stack #(
  parameter int ROUTINES    = 64,
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [5:0]  routine_id_i,
  input  logic [63:0] frame_pointer_i,
  input  logic [63:0] code_address_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] call_index_o,
  output logic [4:0]  stack_depth_o
);

  import pss_pkg::*;

  localparam int RID_W   = (ROUTINES > 1) ? $clog2(ROUTINES) : 1;
  localparam int DEP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRIES = ROUTINES * STACK_DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  pss_state_e         state_q, state_d;
  logic               mode_q;
  logic [RID_W-1:0]   rid_q;
  logic [ADDR_W-1:0]  base_q;
  logic [63:0]        fp_q;
  logic [63:0]        ca_q;
  logic [DEP_W-1:0]   depth_q, depth_d;
  logic [RID_W-1:0]   clr_q, clr_d;
  logic [31:0]        counter_q, counter_d;
  logic               done_q, done_d;
  logic [2:0]         status_q, status_d;
  logic [31:0]        index_q, index_d;
  logic [4:0]         sdepth_q, sdepth_d;

  logic [5:0]         rid_rem;
  logic [RID_W-1:0]   rid_in;
  logic               accept;

  logic               dep_en, dep_we;
  logic [RID_W-1:0]   dep_addr;
  logic [DEP_W-1:0]   dep_wdata, dep_rdata;

  logic               ent_en, ent_we;
  logic [DEP_W-1:0]   slot;
  logic [ADDR_W-1:0]  ent_addr;
  pss_entry_t         ent_wdata, ent_rdata;

  // reduce the id modulo ROUTINES by restoring subtraction
  always_comb begin
    rid_rem = routine_id_i;
    for (int k = 5; k >= 0; k--) begin
      if ((ROUTINES << k) <= 63) begin
        if (32'(rid_rem) >= (ROUTINES << k)) begin
          rid_rem = rid_rem - 6'(ROUTINES << k);
        end
      end
    end
  end

  assign rid_in = RID_W'(rid_rem);
  assign busy   = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == RID_W'(ROUTINES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_d = S_DEPTH;
      end
      S_DEPTH: begin
        if (mode_q == MODE_RETURN && dep_rdata != '0) state_d = S_CHECK;
        else state_d = S_IDLE;
      end
      S_CHECK: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    dep_en    = 1'b0;
    dep_we    = 1'b0;
    dep_addr  = rid_q;
    dep_wdata = '0;
    ent_en    = 1'b0;
    ent_we    = 1'b0;
    slot      = '0;
    ent_wdata = '{frame: fp_q, ret: ca_q, index: counter_q};
    depth_d   = depth_q;
    clr_d     = clr_q;
    counter_d = counter_q;
    done_d    = 1'b0;
    status_d  = status_q;
    index_d   = index_q;
    sdepth_d  = sdepth_q;
    case (state_q)
      S_CLEAR: begin
        dep_en   = 1'b1;
        dep_we   = 1'b1;
        dep_addr = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      S_IDLE: begin
        dep_en   = start;
        dep_addr = rid_in;
      end
      S_DEPTH: begin
        depth_d  = dep_rdata;
        sdepth_d = 5'(dep_rdata);
        if (mode_q == MODE_CALL) begin
          done_d  = 1'b1;
          index_d = counter_q;
          if (dep_rdata >= DEP_W'(STACK_DEPTH)) begin
            status_d = ST_FULL;
          end else begin
            status_d  = ST_PUSHED;
            slot      = dep_rdata;
            ent_en    = 1'b1;
            ent_we    = 1'b1;
            dep_en    = 1'b1;
            dep_we    = 1'b1;
            dep_wdata = dep_rdata + 1'b1;
            counter_d = counter_q + 32'd1;
          end
        end else if (dep_rdata == '0) begin
          done_d   = 1'b1;
          status_d = ST_EMPTY;
          index_d  = '0;
        end else begin
          slot   = dep_rdata - 1'b1;
          ent_en = 1'b1;
        end
      end
      S_CHECK: begin
        done_d  = 1'b1;
        index_d = ent_rdata.index;
        if (ent_rdata.frame != fp_q) begin
          status_d = ST_FRAME_BAD;
        end else if (ent_rdata.ret != ca_q) begin
          status_d = ST_RET_BAD;
        end else begin
          status_d  = ST_RET_OK;
          dep_en    = 1'b1;
          dep_we    = 1'b1;
          dep_wdata = depth_q - 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  assign ent_addr = base_q + ADDR_W'(slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      counter_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      counter_q <= counter_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      rid_q  <= rid_in;
      base_q <= ADDR_W'(rid_in * STACK_DEPTH);
      fp_q   <= frame_pointer_i;
      ca_q   <= code_address_i;
    end
    depth_q  <= depth_d;
    status_q <= status_d;
    index_q  <= index_d;
    sdepth_q <= sdepth_d;
  end

  pss_depth_mem #(
    .DEPTH  (ROUTINES),
    .ADDR_W (RID_W),
    .WIDTH  (DEP_W)
  ) u_depth_mem (
    .clk_i   (clk_i),
    .en_i    (dep_en),
    .we_i    (dep_we),
    .addr_i  (dep_addr),
    .wdata_i (dep_wdata),
    .rdata_o (dep_rdata)
  );

  pss_entry_mem #(
    .DEPTH  (ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .en_i    (ent_en),
    .we_i    (ent_we),
    .addr_i  (ent_addr),
    .wdata_i (ent_wdata),
    .rdata_o (ent_rdata)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign call_index_o  = index_q;
  assign stack_depth_o = sdepth_q;

  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_DEPTH || $past(state_q) == S_CHECK))
    else $error("result strobe without a finishing state");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEPTH |-> dep_rdata <= DEP_W'(STACK_DEPTH))
    else $error("stack depth beyond bound");

  a_counter_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counter_q != $past(counter_q) |-> (done_o && status_o == ST_PUSHED))
    else $error("call counter advanced without a push");

  a_accept_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == S_DEPTH)
    else $error("command transfer did not start a depth read");

endmodule
